// File: hdl/bsh_pkg.sv
`default_nettype none
package bsh_pkg;

   localparam int NumWords = 8;
   localparam int BlockBytes = 64;

   localparam logic [63:0] MixConst [NumWords] = '{
      64'h9e3779b97f4a7c15, 64'hbf58476d1ce4e5b9,
      64'h94d049bb133111eb, 64'hff51afd7ed558ccd,
      64'h1337c0debabefeed, 64'hdeadbeefcafeface,
      64'h8badf00dcafebabe, 64'hfeedfacedeadc0de
   };

   localparam logic [7:0] PadFirst = 8'h80;
   localparam logic [7:0] PadFill  = 8'h13;

   localparam logic OpAbsorb   = 1'b0;
   localparam logic OpFinalize = 1'b1;

   // datapath operations
   typedef enum logic [2:0] {
      DP_NOP,
      DP_WRITE,     // store byte at fill position
      DP_LOAD,      // not decoded by the datapath; acts as a no-op
      DP_MIX,       // run one mix step
      DP_AVAL,      // run one avalanche step
      DP_INIT       // restore chaining state
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [7:0] wr_byte;
   } dp_cmd_type;

   typedef struct packed {
      logic block_full;   // the current write fills the block
      logic step_done;    // current multi-cycle step finished
      logic [5:0] fill;
   } dp_sts_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
      rotl = (x << n) | (x >> (64 - n));
   endfunction

endpackage
`default_nettype wire

// File: hdl/bsh_if.sv
`default_nettype none
interface bsh_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;
   modport source (output valid, opcode, data_byte, input ready);
   modport sink   (input valid, opcode, data_byte, output ready);
endinterface

interface bsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// File: hdl/bsh_ram.sv
`default_nettype none
module bsh_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: hdl/bsh_datapath.sv
`default_nettype none
module bsh_datapath
   import bsh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire dp_cmd_type cmd,
   output      dp_sts_type sts,
   input  wire logic [2:0] out_sel,
   output      logic [63:0] out_word
);
   logic [63:0] chain_ff [NumWords];
   logic [63:0] chain_in [NumWords];
   logic [5:0]  fill_ff, fill_in;
   // read pointer: 6 bits byte address; the RAM is addressed with its next value
   logic [5:0]  rd_ptr_ff, rd_ptr_in;
   logic        rd_vld_ff, rd_vld_in;
   logic [63:0] word_ff, word_in;
   logic [2:0]  byte_cnt_ff, byte_cnt_in;  // bytes assembled into word
   logic        word_rdy_ff, word_rdy_in;
   logic [1:0]  round_ff, round_in;
   logic [2:0]  phase_ff, phase_in;        // mix sub-phase
   logic [63:0] a_ff, a_in, b_ff, b_in, p_ff, p_in;
   logic [2:0]  aval_ff, aval_in;
   logic [1:0]  aph_ff, aph_in;
   logic [2:0]  words_done_ff, words_done_in;
   logic        done;
   logic [7:0]  rd_data;
   logic [2:0]  r, rb, rn, ai, aj;
   // shared 32x32 multiplier, three passes give the low 64 bits of a product
   logic [63:0] mx, my;
   logic [1:0]  mstep;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p, p_step;

   bsh_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
      .clock   (clock),
      .wr_en   (cmd.op == DP_WRITE),
      .wr_addr (fill_ff),
      .wr_data (cmd.wr_byte),
      .rd_addr (rd_ptr_in),
      .rd_data (rd_data)
   );

   assign r  = {1'b0, round_ff};
   assign rb = 3'd7 - r;
   assign rn = r + 3'd1;
   assign ai = aval_ff;
   assign aj = aval_ff + 3'd3;

   always_comb begin
      if (cmd.op == DP_AVAL) begin
         mx = chain_ff[aj]; my = MixConst[3'd7 - ai]; mstep = aph_ff;
      end else begin
         mx = a_ff; my = MixConst[0]; mstep = phase_ff[1:0] - 2'd1;
      end
      unique case (mstep)
         2'd0: begin mul_a = mx[31:0];  mul_b = my[31:0];  end
         2'd1: begin mul_a = mx[31:0];  mul_b = my[63:32]; end
         default: begin mul_a = mx[63:32]; mul_b = my[31:0]; end
      endcase
      mul_p = {32'b0, mul_a} * {32'b0, mul_b};
      if (mstep == 2'd0) p_step = mul_p;
      else p_step = {p_ff[63:32] + mul_p[31:0], p_ff[31:0]};
   end

   always_comb begin
      for (int i = 0; i < NumWords; i++) chain_in[i] = chain_ff[i];
      fill_in = fill_ff;
      rd_ptr_in = rd_ptr_ff; rd_vld_in = 1'b0;
      word_in = word_ff; byte_cnt_in = byte_cnt_ff; word_rdy_in = word_rdy_ff;
      round_in = round_ff; phase_in = phase_ff;
      a_in = a_ff; b_in = b_ff; p_in = p_ff;
      aval_in = aval_ff; aph_in = aph_ff;
      words_done_in = words_done_ff;
      done = 1'b0;
      unique case (cmd.op)
         DP_WRITE: fill_in = fill_ff + 6'd1;
         DP_INIT: begin
            for (int i = 0; i < NumWords; i++) chain_in[i] = MixConst[i];
            fill_in = '0;
            aval_in = '0; aph_in = '0;
         end
         DP_MIX: begin
            // byte fetch runs ahead while word not ready
            if (!word_rdy_ff) begin
               rd_vld_in = 1'b1;
               if (rd_vld_ff) begin
                  word_in = {rd_data, word_ff[63:8]};
                  byte_cnt_in = byte_cnt_ff + 3'd1;
                  if (byte_cnt_ff == 3'd7) begin
                     word_rdy_in = 1'b1;
                     rd_vld_in = 1'b0;
                  end else begin
                     rd_ptr_in = rd_ptr_ff + 6'd1;
                  end
               end
            end else begin
               unique case (phase_ff)
                  3'd0: begin
                     a_in = chain_ff[r] ^ word_ff ^ MixConst[r + 3'd4];
                     b_in = chain_ff[rb];
                     phase_in = 3'd1;
                  end
                  3'd1: begin
                     b_in = b_ff + rotl(a_ff, 19);
                     p_in = p_step;
                     phase_in = 3'd2;
                  end
                  3'd2: begin
                     p_in = p_step;
                     phase_in = 3'd3;
                  end
                  3'd3: begin
                     p_in = p_step;
                     phase_in = 3'd4;
                  end
                  3'd4: begin
                     b_in = b_ff ^ (p_ff >> 13);
                     chain_in[rb] = b_ff ^ (p_ff >> 13);
                     chain_in[r] = p_ff + (b_ff ^ (p_ff >> 13));
                     phase_in = 3'd5;
                  end
                  default: begin
                     // rn may equal rb for r==3, so read updated chain
                     chain_in[r] = chain_ff[r] ^ (chain_ff[rn] + MixConst[r]);
                     phase_in = 3'd0;
                     round_in = round_ff + 2'd1;
                     if (round_ff == 2'd3) begin
                        word_rdy_in = 1'b0;
                        byte_cnt_in = '0;
                        rd_ptr_in = rd_ptr_ff + 6'd1;
                        words_done_in = words_done_ff + 3'd1;
                        if (words_done_ff == 3'd7) done = 1'b1;
                     end
                  end
               endcase
            end
         end
         DP_AVAL: begin
            if (aph_ff != 2'd3) begin
               p_in = p_step;
               aph_in = aph_ff + 2'd1;
            end else begin
               chain_in[ai] = rotl(chain_ff[ai] ^ p_ff, 31);
               aph_in = '0;
               aval_in = aval_ff + 3'd1;
               if (aval_ff == 3'd7) done = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumWords; i++) chain_ff[i] <= MixConst[i];
         fill_ff <= '0; rd_ptr_ff <= '0; rd_vld_ff <= 1'b0;
         byte_cnt_ff <= '0; word_rdy_ff <= 1'b0; round_ff <= '0; phase_ff <= '0;
         aval_ff <= '0; aph_ff <= '0; words_done_ff <= '0;
      end else begin
         for (int i = 0; i < NumWords; i++) chain_ff[i] <= chain_in[i];
         fill_ff <= fill_in; rd_ptr_ff <= rd_ptr_in; rd_vld_ff <= rd_vld_in;
         byte_cnt_ff <= byte_cnt_in; word_rdy_ff <= word_rdy_in;
         round_ff <= round_in; phase_ff <= phase_in;
         aval_ff <= aval_in; aph_ff <= aph_in; words_done_ff <= words_done_in;
      end
      word_ff <= word_in; a_ff <= a_in; b_ff <= b_in; p_ff <= p_in;
   end

   assign sts.block_full = (cmd.op == DP_WRITE) && (fill_ff == 6'd63);
   assign sts.step_done  = done;
   assign sts.fill       = fill_ff;
   assign out_word       = chain_ff[out_sel];
endmodule
`default_nettype wire

// File: hdl/bsh_ctrl.sv
`default_nettype none
module bsh_ctrl
   import bsh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   bsh_req_if.sink         req,
   input  wire logic       rsp_ready,
   output      logic       rsp_valid,
   output      logic [2:0] rsp_sel,
   output      dp_cmd_type cmd,
   input  wire dp_sts_type sts
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_PAD  = 6'b000010,
      S_MIX  = 6'b000100,
      S_AVAL = 6'b001000,
      S_OUT  = 6'b010000,
      S_INIT = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic       fin_ff, fin_in;     // finalize in progress
   logic [2:0] sel_ff, sel_in;
   logic       acc;

   assign req.ready = (state_ff == S_IDLE);
   assign acc       = req.valid && req.ready;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_sel   = sel_ff;

   always_comb begin
      state_in = state_ff; fin_in = fin_ff; sel_in = sel_ff;
      cmd.op = DP_NOP; cmd.wr_byte = req.data_byte;
      unique case (state_ff)
         S_IDLE: if (acc) begin
            cmd.op = DP_WRITE;
            if (req.opcode == OpFinalize) begin
               cmd.wr_byte = PadFirst;
               fin_in = 1'b1;
            end
            if (sts.block_full) state_in = S_MIX;
            else if (req.opcode == OpFinalize) state_in = S_PAD;
         end
         S_PAD: begin
            cmd.op = DP_WRITE; cmd.wr_byte = PadFill;
            if (sts.block_full) state_in = S_MIX;
         end
         S_MIX: begin
            cmd.op = DP_MIX;
            if (sts.step_done) state_in = fin_ff ? S_AVAL : S_IDLE;
         end
         S_AVAL: begin
            cmd.op = DP_AVAL;
            if (sts.step_done) begin state_in = S_OUT; sel_in = '0; end
         end
         S_OUT: if (rsp_ready) begin
            sel_in = sel_ff + 3'd1;
            if (sel_ff == 3'd7) state_in = S_INIT;
         end
         S_INIT: begin
            cmd.op = DP_INIT; fin_in = 1'b0; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; fin_ff <= 1'b0; sel_ff <= '0;
      end else begin
         state_ff <= state_in; fin_ff <= fin_in; sel_ff <= sel_in;
      end
   end
endmodule
`default_nettype wire

// File: hdl/byte_stream_hash_512_unit.sv
`default_nettype none
// 512-bit byte-stream hash. One request carries a byte (opcode 0) or a
// finalize (opcode 1). An absorb that fills the 64-byte block starts a mix:
// the block is mixed word by word, each word assembled byte by byte through
// the byte-wide buffer port and run through the six-phase mix round, whose
// 64-bit constant multiply runs as three passes through one shared 32x32
// multiplier. Finalize pads (one cycle per pad byte, up to 64 writes
// including the 0x80), mixes the last block, runs the avalanche and then
// returns eight responses, digest words 0..7, last_word on word 7, one per
// cycle while the receiver is ready. An init state then restores the state,
// and the next request is taken.
module byte_stream_hash_512_unit
   import bsh_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   bsh_req_if.sink   req,
   bsh_rsp_if.source rsp
);
   dp_cmd_type  cmd;
   dp_sts_type  sts;
   logic [2:0]  sel;
   logic [63:0] word;
   logic        vld;

   bsh_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp_ready(rsp.ready),
      .rsp_valid(vld), .rsp_sel(sel), .cmd(cmd), .sts(sts)
   );

   bsh_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .out_sel(sel), .out_word(word)
   );

   assign rsp.valid       = vld;
   assign rsp.digest_word = word;
   assign rsp.word_index  = sel;
   assign rsp.last_word   = (sel == 3'd7);
endmodule
`default_nettype wire

// File: sim/tb_byte_stream_hash_512_unit.sv
`timescale 1ns / 100ps
`default_nettype none
// Testbench for the 512-bit byte-stream hash unit.
module tb_byte_stream_hash_512_unit;
   import bsh_pkg::*;

   // --------------------------------------------------------------------
   // Hash predictor: its own copy of the chaining state and block buffer.
   // --------------------------------------------------------------------
   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_rsp_type;

   class digest_scoreboard;
      logic [63:0] chain [NumWords];
      logic [7:0]  blk [BlockBytes];
      int unsigned fill;
      digest_rsp_type pending_words [$];
      int unsigned n_digests;
      int unsigned n_blocks;

      function new();
         restart();
         fill = 0;
         n_digests = 0;
         n_blocks = 0;
      endfunction

      function void restart();
         for (int i = 0; i < NumWords; i++) chain[i] = MixConst[i];
      endfunction

      function logic [63:0] rot(logic [63:0] x, int unsigned n);
         return (x << n) | (x >> (64 - n));
      endfunction

      function void churn_block();
         logic [63:0] w, a, b;
         n_blocks++;
         for (int wi = 0; wi < NumWords; wi++) begin
            w = '0;
            for (int k = 0; k < 8; k++) w |= 64'(blk[wi*8+k]) << (8*k);
            for (int r = 0; r < 4; r++) begin
               a = chain[r];
               b = chain[7-r];
               a ^= w ^ MixConst[r+4];
               b += rot(a, 19);
               a *= MixConst[0];
               b ^= a >> 13;
               a += b;
               chain[r] = a;
               chain[7-r] = b;
               chain[r] ^= chain[(r+1) & 7] + MixConst[r];
            end
         end
      endfunction

      function void take_byte(logic [7:0] x);
         blk[fill] = x;
         fill = (fill + 1) % BlockBytes;
         if (fill == 0) churn_block();
      endfunction

      // note an accepted request
      function void note_request(logic op, logic [7:0] x);
         logic [63:0] s;
         digest_rsp_type e;
         if (op == OpAbsorb) begin
            take_byte(x);
            return;
         end
         take_byte(PadFirst);
         while (fill != 0) take_byte(PadFill);
         for (int i = 0; i < NumWords; i++) begin
            s = chain[i] ^ (chain[(i+3) & 7] * MixConst[7-i]);
            chain[i] = rot(s, 31);
         end
         for (int i = 0; i < NumWords; i++) begin
            e.digest_word = chain[i];
            e.word_index = 3'(i);
            e.last_word = (i == 7);
            pending_words.push_back(e);
         end
         restart();
         fill = 0;
         n_digests++;
      endfunction

      // returns a mismatch description, empty when fine
      function string check_word(digest_rsp_type got);
         digest_rsp_type e;
         if (pending_words.size() == 0)
            return $sformatf("unexpected word %h idx %0d", got.digest_word, got.word_index);
         e = pending_words.pop_front();
         if (got.digest_word !== e.digest_word)
            return $sformatf("digest_word %h, want %h (idx %0d)",
                             got.digest_word, e.digest_word, e.word_index);
         if (got.word_index !== e.word_index)
            return $sformatf("word_index %0d, want %0d", got.word_index, e.word_index);
         if (got.last_word !== e.last_word)
            return $sformatf("last_word %0b, want %0b (idx %0d)",
                             got.last_word, e.last_word, e.word_index);
         return "";
      endfunction
   endclass

   // --------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // --------------------------------------------------------------------
   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   bsh_req_if req ();
   bsh_rsp_if rsp ();

   byte_stream_hash_512_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   digest_scoreboard sb = new();
   int unsigned n_errors = 0;
   int unsigned n_requests = 0;
   int unsigned n_words = 0;
   int unsigned idle_cycles = 0;

   // idle / stall percentages, set per phase
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit hold_rsp = 1'b0;        // long receiver hold-off in progress
   bit start_hold = 1'b0;

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      n_errors++;
   endtask

   // receiver: random stall, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long hold-off counted here; sender keeps offering meanwhile
   initial begin
      wait (start_hold);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (3000) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // response checker
   always @(posedge clock) begin
      digest_rsp_type got;
      string msg;
      if (!reset && rsp.valid && rsp.ready) begin
         got.digest_word = rsp.digest_word;
         got.word_index = rsp.word_index;
         got.last_word = rsp.last_word;
         msg = sb.check_word(got);
         n_words++;
         if (msg != "") report(msg);
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog expired, %0d words outstanding", sb.pending_words.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // send one request; valid stays high across back-to-back requests
   task automatic send_request(input logic op, input logic [7:0] x);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.opcode <= op;
      req.data_byte <= x;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_request(op, x);
      n_requests++;
   endtask

   task automatic park_sender();
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   // sender pause until every expected digest word has come
   task automatic wait_drained();
      park_sender();
      while (sb.pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic send_message(input int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         send_request(OpAbsorb, 8'($urandom_range(255)));
      send_request(OpFinalize, 8'($urandom_range(255)));
   endtask

   // random message length: mostly short, some near the block edges
   function automatic int unsigned pick_len();
      case ($urandom_range(9))
         0: return 63;
         1: return 64;
         2: return $urandom_range(120, 62);
         default: return $urandom_range(20);
      endcase
   endfunction

   // random phase: mostly well-formed messages with random content
   task automatic random_phase(input int unsigned n_items);
      int unsigned start;
      start = n_requests;
      while (n_requests - start < n_items) begin
         if ($urandom_range(9) == 0)
            send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
         else
            send_message(pick_len());
      end
   endtask

   initial begin
      req.valid <= 1'b0;
      req.opcode <= OpAbsorb;
      req.data_byte <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, byte extremes, partial block edges
      send_request(OpFinalize, 8'hff);        // empty message
      send_request(OpAbsorb, 8'h00);
      send_request(OpAbsorb, 8'hff);
      send_request(OpAbsorb, 8'h55);
      send_request(OpAbsorb, 8'haa);
      send_request(OpFinalize, 8'h00);
      send_request(OpFinalize, 8'h5a);        // back-to-back finalize
      wait_drained();
      send_message(63);                       // pad byte completes block
      send_message(64);                       // exact block boundary
      wait_drained();

      // random phases with varied idling
      send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(50);
      send_idle_pct = 74; recv_stall_pct = 0;  random_phase(40);
      wait_drained();
      send_idle_pct = 0;  recv_stall_pct = 74; random_phase(40);

      // receiver holds off long while sender keeps pushing: block backs up
      send_idle_pct = 0;  recv_stall_pct = 0;
      start_hold = 1'b1;
      for (int i = 0; i < 6; i++) send_message($urandom_range(8));
      wait_drained();

      send_idle_pct = 21; recv_stall_pct = 21; random_phase(40);
      send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(30);
      wait_drained();

      repeat (DrainCycles) @(posedge clock);
      $display("covered %0d requests, %0d digests, %0d blocks mixed, %0d words checked",
               n_requests, sb.n_digests, sb.n_blocks, n_words);
      $display("stall mixes: none, sender idle, receiver stall, both, long hold-off");
      if (n_errors == 0 && sb.pending_words.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d words missing", n_errors, sb.pending_words.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: byte_stream_hash_512_unit.f
hdl/bsh_pkg.sv
hdl/bsh_if.sv
hdl/bsh_ram.sv
hdl/bsh_datapath.sv
hdl/bsh_ctrl.sv
hdl/byte_stream_hash_512_unit.sv
sim/tb_byte_stream_hash_512_unit.sv
